// ===== rtl/cfss_pkg.sv =====
// Shared types and constants for the camera focus and shutter sequencer.
package cfss_pkg;

  localparam int unsigned TicksW  = 27;
  localparam int unsigned HoldW   = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = TicksW;

  // Timer ticks per second and the reset values derived from it.
  localparam logic [TicksW-1:0] OneSecondTicks = TicksW'(32'h00F4_2400);
  localparam logic [TicksW-1:0] LongDelayRst   = TicksW'(8 * 32'h00F4_2400);
  localparam logic [TicksW-1:0] ShortDelayRst  = TicksW'(2 * 32'h00F4_2400);
  localparam logic [HoldW-1:0]  HoldStepsRst   = HoldW'(32000);

  typedef enum logic [1:0] {
    MODE_SENSOR = 2'd0,
    MODE_MANUAL = 2'd1,
    MODE_DEACT  = 2'd2
  } camera_mode_t;

  typedef enum logic [1:0] {
    TCMD_NONE  = 2'd0,
    TCMD_START = 2'd1,
    TCMD_STOP  = 2'd2
  } timer_cmd_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CAMERA_MODE = 3'd0,
    REG_LONG_DELAY  = 3'd1,
    REG_SHORT_DELAY = 3'd2,
    REG_IDLE_DELAY  = 3'd3,
    REG_HOLD_STEPS  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    camera_mode_t      camera_mode;
    logic [TicksW-1:0] long_delay_ticks;
    logic [TicksW-1:0] short_delay_ticks;
    logic [TicksW-1:0] idle_delay_ticks;
    logic [HoldW-1:0]  shutter_hold_steps;
  } cfg_t;

  typedef struct packed {
    logic manual_request;
    logic sensor_trigger;
    logic first_picture;
    logic shoot_submode;
    logic timer_fired;
  } step_word_t;

  typedef struct packed {
    logic             shoot_running;
    logic             fired_latch;
    logic             manual_pending;
    logic [HoldW-1:0] hold_count;
    logic             focus_pin;
    logic             shutter_pin;
  } seq_state_t;

  typedef struct packed {
    logic              focus_level;
    logic              shutter_level;
    timer_cmd_t        timer_command;
    logic              reload_valid;
    logic [TicksW-1:0] reload_ticks;
    logic              picture_taken;
  } result_word_t;

endpackage

// ===== rtl/cfss_step.sv =====
// Combinational step logic: next sequencer state and result word for one input word.
module cfss_step (
  input  cfss_pkg::cfg_t         cfg,
  input  cfss_pkg::seq_state_t   st,
  input  cfss_pkg::step_word_t   word,
  output cfss_pkg::seq_state_t   st_next,
  output cfss_pkg::result_word_t res
);
  import cfss_pkg::*;

  logic             shoot;
  logic             go;
  logic [HoldW-1:0] hold_inc;

  always_comb begin
    st_next                = st;
    st_next.manual_pending = st.manual_pending | word.manual_request;
    st_next.fired_latch    = st.fired_latch | word.timer_fired;
    res                    = '0;
    res.timer_command      = TCMD_NONE;
    shoot                  = 1'b0;
    go                     = 1'b0;
    hold_inc               = st.hold_count + HoldW'(1);

    case (cfg.camera_mode)
      MODE_SENSOR: begin
        go = word.sensor_trigger | st.shoot_running;
        if (word.shoot_submode) begin
          // continuous focus: focus pin stays up in every step
          st_next.focus_pin = 1'b1;
          if (go) begin
            st_next.shoot_running = 1'b1;
            if (word.first_picture) begin
              shoot = 1'b1;
            end else begin
              res.timer_command = TCMD_START;
              shoot             = st_next.fired_latch;
            end
          end else begin
            res.timer_command   = TCMD_STOP;
            res.reload_valid    = 1'b1;
            res.reload_ticks    = cfg.idle_delay_ticks;
            st_next.shutter_pin = 1'b0;
          end
        end else begin
          if (go) begin
            st_next.shoot_running = 1'b1;
            if (word.sensor_trigger) begin
              res.reload_valid = 1'b1;
              res.reload_ticks = word.first_picture ? cfg.long_delay_ticks
                                                    : cfg.short_delay_ticks;
            end
            res.timer_command = TCMD_START;
            st_next.focus_pin = 1'b1;
            shoot             = st_next.fired_latch;
          end else begin
            res.timer_command   = TCMD_STOP;
            res.reload_valid    = 1'b1;
            res.reload_ticks    = cfg.idle_delay_ticks;
            st_next.focus_pin   = 1'b0;
            st_next.shutter_pin = 1'b0;
          end
        end
      end
      MODE_MANUAL: begin
        if (st_next.manual_pending | st.shoot_running) begin
          st_next.shoot_running = 1'b1;
          if (st_next.manual_pending) begin
            res.reload_valid       = 1'b1;
            res.reload_ticks       = cfg.long_delay_ticks;
            st_next.manual_pending = 1'b0;
          end
          res.timer_command = TCMD_START;
          st_next.focus_pin = 1'b1;
          shoot             = st_next.fired_latch;
        end else begin
          res.timer_command   = TCMD_STOP;
          res.reload_valid    = 1'b1;
          res.reload_ticks    = cfg.idle_delay_ticks;
          st_next.focus_pin   = 1'b0;
          st_next.shutter_pin = 1'b0;
        end
      end
      default: begin
        // deactivated or unused code: only the latches move
      end
    endcase

    // Shutter hold: count, and end the shoot once the hold is complete.
    if (shoot) begin
      if (hold_inc >= cfg.shutter_hold_steps) begin
        st_next.hold_count     = '0;
        st_next.fired_latch    = 1'b0;
        st_next.shoot_running  = 1'b0;
        st_next.manual_pending = 1'b0;
        res.picture_taken      = 1'b1;
      end else begin
        st_next.hold_count  = hold_inc;
        st_next.focus_pin   = 1'b1;
        st_next.shutter_pin = 1'b1;
      end
    end

    res.focus_level   = st_next.focus_pin;
    res.shutter_level = st_next.shutter_pin;
  end

endmodule

// ===== rtl/camera_focus_shutter_sequencer_unit.sv =====
// Top level of the camera focus and shutter sequencer: config, state and result registers.
// The result word is registered: it is valid in the cycle after its input word is accepted.
// Throughput: one word per clock; the input is ready whenever the result register
//   is empty or is being drained in the same cycle, so a stalled output holds one word.
// Reset (synchronous, rst high): registers go to mode manual, delays 8 s / 2 s / 1 s,
//   hold of 32000 steps; all sequencer state and the result valid flag clear.
module camera_focus_shutter_sequencer_unit (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write port
  input  logic                            cfg_write,
  input  logic [cfss_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [cfss_pkg::CfgW-1:0]       cfg_data,
  // input words
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            manual_request,
  input  logic                            sensor_trigger,
  input  logic                            first_picture,
  input  logic                            shoot_submode,
  input  logic                            timer_fired,
  // result words
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            focus_level,
  output logic                            shutter_level,
  output logic [1:0]                      timer_command,
  output logic                            reload_valid,
  output logic [cfss_pkg::TicksW-1:0]     reload_ticks,
  output logic                            picture_taken
);
  import cfss_pkg::*;

  cfg_t         cfg;
  seq_state_t   st;
  seq_state_t   st_next;
  seq_state_t   st_reg_next;
  step_word_t   word;
  result_word_t res;
  result_word_t res_next;
  logic         in_accept;
  logic         mode_change;

  // Pack the input word for the step logic.
  assign word = '{
    manual_request: manual_request,
    sensor_trigger: sensor_trigger,
    first_picture:  first_picture,
    shoot_submode:  shoot_submode,
    timer_fired:    timer_fired
  };

  // Accept when the result register is free or empties this cycle.
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  cfss_step u_step (
    .cfg     (cfg),
    .st      (st),
    .word    (word),
    .st_next (st_next),
    .res     (res_next)
  );

  // A mode write that changes the mode drops any pending manual trigger.
  assign mode_change = cfg_write && (cfg_index == REG_CAMERA_MODE) &&
                       (cfg_data[1:0] != cfg.camera_mode);

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.camera_mode        <= MODE_MANUAL;
      cfg.long_delay_ticks   <= LongDelayRst;
      cfg.short_delay_ticks  <= ShortDelayRst;
      cfg.idle_delay_ticks   <= OneSecondTicks;
      cfg.shutter_hold_steps <= HoldStepsRst;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CAMERA_MODE: cfg.camera_mode        <= camera_mode_t'(cfg_data[1:0]);
        REG_LONG_DELAY:  cfg.long_delay_ticks   <= cfg_data[TicksW-1:0];
        REG_SHORT_DELAY: cfg.short_delay_ticks  <= cfg_data[TicksW-1:0];
        REG_IDLE_DELAY:  cfg.idle_delay_ticks   <= cfg_data[TicksW-1:0];
        REG_HOLD_STEPS:  cfg.shutter_hold_steps <= cfg_data[HoldW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Advance on an accepted word, then drop the pending trigger on a mode change.
  always_comb begin
    st_reg_next = in_accept ? st_next : st;
    if (mode_change) begin
      st_reg_next.manual_pending = 1'b0;
    end
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else begin
      st <= st_reg_next;
    end
  end

  // Result register: load on accept, hold while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      res <= res_next;
    end
  end

  assign focus_level   = res.focus_level;
  assign shutter_level = res.shutter_level;
  assign timer_command = res.timer_command;
  assign reload_valid  = res.reload_valid;
  assign reload_ticks  = res.reload_ticks;
  assign picture_taken = res.picture_taken;

  // A completed hold ends the shoot and rewinds the hold counter.
  a_taken_ends_shoot: assert property (@(posedge clk) disable iff (rst)
    in_accept && res_next.picture_taken |=> !st.shoot_running && (st.hold_count == '0))
    else $error("picture taken but shoot state not cleared");

  // No reload word means a zero reload value.
  a_reload_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !res.reload_valid |-> (res.reload_ticks == '0))
    else $error("reload ticks nonzero without reload_valid");

  // Stopping the timer always comes with the idle reload.
  a_stop_reloads: assert property (@(posedge clk) disable iff (rst)
    out_valid && (res.timer_command == TCMD_STOP) |-> res.reload_valid)
    else $error("timer stop without reload");

  // Deactivated mode leaves the hold counter and focus pin alone.
  a_deact_quiet: assert property (@(posedge clk) disable iff (rst)
    in_accept && (cfg.camera_mode == MODE_DEACT) |=>
      (st.hold_count == $past(st.hold_count)) && (st.focus_pin == $past(st.focus_pin)))
    else $error("state moved in deactivated mode");

endmodule
